/* sv/spq_pkg.sv */
// ============================================================================
// spq_pkg
// Shared types and codes for the stable priority queue.
// ============================================================================
package spq_pkg;

    localparam int VALUE_W = 32;
    localparam int PRIO_FIELD_W = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W = 5;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic enq;
        logic deq;
    } spq_ctrl_t;

endpackage

/* sv/spq_cell.sv */
// ============================================================================
// spq_cell
// One slot of the sorted chain: holds an entry and moves it left or right.
// ============================================================================
module spq_cell import spq_pkg::*; #(
    parameter int PW = 8
) (
    input  logic               aclk,
    input  spq_ctrl_t          ctrl,
    input  logic               held,
    input  logic [VALUE_W-1:0] new_value,
    input  logic [PW-1:0]      new_prio,
    input  logic               left_after,
    input  logic [VALUE_W-1:0] left_value,
    input  logic [PW-1:0]      left_prio,
    input  logic [VALUE_W-1:0] right_value,
    input  logic [PW-1:0]      right_prio,
    output logic [VALUE_W-1:0] value,
    output logic [PW-1:0]      prio,
    output logic               after
);

    logic [VALUE_W-1:0] value_reg, value_next;
    logic [PW-1:0]      prio_reg, prio_next;

    assign after = held && (prio_reg >= new_prio);
    assign value = value_reg;
    assign prio  = prio_reg;

    always_comb begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.enq && !after) begin
            if (left_after) begin
                value_next = new_value;
                prio_next  = new_prio;
            end else begin
                value_next = left_value;
                prio_next  = left_prio;
            end
        end else if (ctrl.deq) begin
            value_next = right_value;
            prio_next  = right_prio;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

endmodule

/* sv/stable_priority_queue_unit.sv */
// ============================================================================
// stable_priority_queue_unit
// Bounded priority queue kept sorted in a chain of cells, FIFO among ties.
// ============================================================================
// Each word on the s_ channel is one request: tuser selects enqueue or
// dequeue, tdata carries the value and priority of an entry to enqueue.
// Every request returns exactly one word on the m_ channel with the
// dequeued entry, a status code and the occupancy after the request.
// Entries sit in a row of DEPTH cells sorted by priority, head first; on
// an enqueue each cell compares its priority with the new one in parallel
// and either holds, takes the new entry, or takes its left neighbor's.
// A dequeue shifts every cell one place toward the head.
// A request is applied to the cell row when it is accepted; its result
// appears on the m_ channel in the cycle after, and one request
// is accepted per cycle while the receiver takes results.
// The result sits in an output register; when the receiver stalls, that
// register holds and s_tready drops until the word is taken.
// Reset empties the queue and clears the output valid; cell contents are
// not cleared since only entries below the count are ever read.
// ============================================================================
module stable_priority_queue_unit import spq_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int PRIO_WIDTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // in_value [31:0], in_priority [39:32]
    input  logic [0:0]  s_tuser,  // req_type [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // out_value [31:0], out_priority [39:32],
                                  // occupancy [44:40], zero fill [47:45]
    output logic [1:0]  m_tuser   // status [1:0]
);

    localparam int PW = (PRIO_WIDTH < PRIO_FIELD_W) ? PRIO_WIDTH : PRIO_FIELD_W;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic               accept;
    logic               req_type;
    logic [VALUE_W-1:0] in_value;
    logic [PW-1:0]      in_prio;
    spq_ctrl_t          ctrl;

    logic [CW-1:0] count_reg, count_next;
    logic          m_valid_reg;
    logic [VALUE_W-1:0]      out_value_reg, out_value_next;
    logic [PRIO_FIELD_W-1:0] out_prio_reg, out_prio_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [OCC_W-1:0]        occ_reg, occ_next;

    logic [VALUE_W-1:0] cell_value [DEPTH];
    logic [PW-1:0]      cell_prio  [DEPTH];
    logic [DEPTH-1:0]   cell_after;
    logic [DEPTH-1:0]   cell_held;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign req_type = s_tuser[0];
    assign in_value = s_tdata[31:0];
    assign in_prio  = s_tdata[32 +: PW];

    assign ctrl.enq = accept && (req_type == REQ_ENQ) && (count_reg != FULL_COUNT);
    assign ctrl.deq = accept && (req_type == REQ_DEQ) && (count_reg != '0);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic               l_after;
            logic [VALUE_W-1:0] l_value, r_value;
            logic [PW-1:0]      l_prio, r_prio;

            assign cell_held[gi] = CW'(gi) < count_reg;

            if (gi == 0) begin : g_head
                assign l_after = 1'b1;
                assign l_value = in_value;
                assign l_prio  = in_prio;
            end else begin : g_body
                assign l_after = cell_after[gi-1];
                assign l_value = cell_value[gi-1];
                assign l_prio  = cell_prio[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign r_value = '0;
                assign r_prio  = '0;
            end else begin : g_inner
                assign r_value = cell_value[gi+1];
                assign r_prio  = cell_prio[gi+1];
            end

            spq_cell #(.PW(PW)) u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .held        (cell_held[gi]),
                .new_value   (in_value),
                .new_prio    (in_prio),
                .left_after  (l_after),
                .left_value  (l_value),
                .left_prio   (l_prio),
                .right_value (r_value),
                .right_prio  (r_prio),
                .value       (cell_value[gi]),
                .prio        (cell_prio[gi]),
                .after       (cell_after[gi])
            );
        end
    endgenerate

    always_comb begin
        count_next     = count_reg;
        out_value_next = '0;
        out_prio_next  = '0;
        status_next    = ST_OK;
        if (ctrl.enq) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.deq) begin
            count_next     = count_reg - 1'b1;
            out_value_next = cell_value[0];
            out_prio_next  = PRIO_FIELD_W'(cell_prio[0]);
        end else if (req_type == REQ_ENQ) begin
            status_next = ST_FULL;
        end else begin
            status_next = ST_EMPTY;
        end
        occ_next = OCC_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_value_reg <= out_value_next;
            out_prio_reg  <= out_prio_next;
            status_reg    <= status_next;
            occ_reg       <= occ_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, occ_reg, out_prio_reg, out_value_reg};
    assign m_tuser  = status_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("entry count exceeds depth");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (req_type == REQ_DEQ) && (count_reg == '0)
        |=> m_tvalid && (m_tuser == ST_EMPTY) && (count_reg == '0))
        else $error("dequeue on empty queue not reported");

    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (req_type == REQ_ENQ) && (count_reg == FULL_COUNT)
        |=> (m_tuser == ST_FULL) && $stable(count_reg))
        else $error("enqueue on full queue changed the queue");

    generate
        for (gi = 0; gi + 1 < DEPTH; gi++) begin : g_order_chk
            a_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
                cell_held[gi+1] |-> (cell_prio[gi] >= cell_prio[gi+1]))
                else $error("queue cells out of priority order");
        end
    endgenerate

endmodule
